[rtl/core/box_wireframe_projector_defines.svh]
// assertion macros for the box wireframe projector checker
// expects i_clk and i_rst_n in the scope of each use
`ifndef BOX_WIREFRAME_PROJECTOR_DEFINES_SVH
`define BOX_WIREFRAME_PROJECTOR_DEFINES_SVH

// same-cycle implication, off during reset
`define BWP_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("bwp: property failed");

// next-cycle implication, off during reset
`define BWP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("bwp: property failed");

`endif

[rtl/core/bwp_pkg.sv]
// shared types, constants and helpers for the box wireframe projector
// no dependencies
`timescale 1ns / 1ps

package bwp_pkg;

    localparam int FRAC_BITS = 16;
    localparam longint ONE_Q = 64'sd1 << FRAC_BITS;
    localparam longint W_MIN = (ONE_Q + 5) / 10;

    localparam int NUM_CORNERS = 8;
    localparam int NUM_EDGES   = 12;

    // divider: magnitude of clip * 2^frac over w, two quotient bits a stage
    localparam int DIV_W      = 32 + FRAC_BITS;
    localparam int DIV_STEP   = 2;
    localparam int DIV_STAGES = (DIV_W + DIV_STEP - 1) / DIV_STEP;
    localparam int DIV_PAD    = DIV_STAGES * DIV_STEP;
    localparam int REM_W      = 33;

    localparam int CFG_IDX_W = 4;
    localparam logic [14:0] SCREEN_W_RST = 15'd1920;
    localparam logic [14:0] SCREEN_H_RST = 15'd1080;

    typedef enum logic [2:0] {
        CFG_ROW_X_A,
        CFG_ROW_X_B,
        CFG_ROW_Y_A,
        CFG_ROW_Y_B,
        CFG_ROW_W_A,
        CFG_ROW_W_B,
        CFG_SCREEN_W,
        CFG_SCREEN_H
    } t_cfg_idx;

    localparam logic [2:0] EDGE_A [NUM_EDGES] = '{
        3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6, 3'd7, 3'd0, 3'd1, 3'd2, 3'd3};
    localparam logic [2:0] EDGE_B [NUM_EDGES] = '{
        3'd1, 3'd2, 3'd3, 3'd0, 3'd5, 3'd6, 3'd7, 3'd4, 3'd4, 3'd5, 3'd6, 3'd7};

    typedef struct packed {
        logic signed [31:0] center_x;
        logic signed [31:0] center_y;
        logic signed [31:0] center_z;
        logic [30:0]        box_width;
        logic [30:0]        box_height;
        logic [30:0]        box_depth;
        logic [31:0]        color_argb;
    } t_box_in;

    typedef struct packed {
        logic signed [31:0] start_x;
        logic signed [31:0] start_y;
        logic signed [31:0] end_x;
        logic signed [31:0] end_y;
        logic [3:0]         edge_index;
        logic [31:0]        edge_color;
        logic               last_edge;
    } t_edge_out;

    typedef struct packed {
        logic [2:0]         corner;
        logic               vis;
        logic signed [31:0] sx;
        logic signed [31:0] sy;
        logic [31:0]        color;
    } t_corner_res;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647) begin
            r = 32'sh7FFFFFFF;
        end else if (v < -64'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

[rtl/core/bwp_corner_pipe.sv]
// corner projection pipeline: corner, matrix rows, divide by w, screen map
// depends on bwp_pkg
`timescale 1ns / 1ps

module bwp_corner_pipe (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic [2:0]           i_corner,
    input  bwp_pkg::t_box_in     i_box,
    input  logic [63:0]          i_row_x_a,
    input  logic [63:0]          i_row_x_b,
    input  logic [63:0]          i_row_y_a,
    input  logic [63:0]          i_row_y_b,
    input  logic [63:0]          i_row_w_a,
    input  logic [63:0]          i_row_w_b,
    input  logic [14:0]          i_screen_w,
    input  logic [14:0]          i_screen_h,
    output logic                 o_valid,
    output bwp_pkg::t_corner_res o_res
);

    typedef struct packed {
        logic [2:0]                    corner;
        logic                          vis;
        logic [31:0]                   color;
        logic [31:0]                   w;
        logic [bwp_pkg::REM_W-1:0]     rem_x;
        logic [bwp_pkg::DIV_PAD-1:0]   num_x;
        logic                          neg_x;
        logic [bwp_pkg::REM_W-1:0]     rem_y;
        logic [bwp_pkg::DIV_PAD-1:0]   num_y;
        logic                          neg_y;
    } t_div;

    typedef struct packed {
        logic [bwp_pkg::REM_W-1:0]   rem;
        logic [bwp_pkg::DIV_PAD-1:0] num;
    } t_dstep;

    function automatic logic signed [31:0] corner_coord(
        input logic signed [31:0] c, input logic [30:0] e, input logic plus);
        logic signed [34:0] d;
        d = plus ? (35'(c) <<< 1) + 35'(signed'({1'b0, e}))
                 : (35'(c) <<< 1) - 35'(signed'({1'b0, e}));
        return bwp_pkg::sat32(64'(d >>> 1));
    endfunction

    function automatic t_dstep div_steps(input logic [bwp_pkg::REM_W-1:0] rem,
        input logic [bwp_pkg::DIV_PAD-1:0] num, input logic [31:0] w);
        logic [bwp_pkg::REM_W-1:0]   r;
        logic [bwp_pkg::DIV_PAD-1:0] n;
        t_dstep                      o;
        r = rem;
        n = num;
        for (int k = 0; k < bwp_pkg::DIV_STEP; k++) begin
            r = {r[bwp_pkg::REM_W-2:0], n[bwp_pkg::DIV_PAD-1]};
            n = {n[bwp_pkg::DIV_PAD-2:0], 1'b0};
            if (r >= bwp_pkg::REM_W'(w)) begin
                r    = r - bwp_pkg::REM_W'(w);
                n[0] = 1'b1;
            end
        end
        o.rem = r;
        o.num = n;
        return o;
    endfunction

    function automatic logic signed [31:0] quot_sat(
        input logic [bwp_pkg::DIV_PAD-1:0] mag, input logic neg);
        logic signed [bwp_pkg::DIV_PAD+1:0] v;
        v = neg ? -signed'({2'b00, mag}) : signed'({2'b00, mag});
        return bwp_pkg::sat32(64'(v));
    endfunction

    function automatic logic [bwp_pkg::DIV_PAD-1:0] abs_shift(input logic signed [31:0] v);
        logic [32:0] a;
        a = v[31] ? 33'(-33'(v)) : 33'(v);
        return bwp_pkg::DIV_PAD'({a[31:0], bwp_pkg::FRAC_BITS'(0)});
    endfunction

    logic signed [31:0] w_coef [9];
    logic signed [31:0] w_off  [3];

    assign w_coef[0] = i_row_x_a[31:0];
    assign w_coef[1] = i_row_x_a[63:32];
    assign w_coef[2] = i_row_x_b[31:0];
    assign w_coef[3] = i_row_y_a[31:0];
    assign w_coef[4] = i_row_y_a[63:32];
    assign w_coef[5] = i_row_y_b[31:0];
    assign w_coef[6] = i_row_w_a[31:0];
    assign w_coef[7] = i_row_w_a[63:32];
    assign w_coef[8] = i_row_w_b[31:0];
    assign w_off[0]  = i_row_x_b[63:32];
    assign w_off[1]  = i_row_y_b[63:32];
    assign w_off[2]  = i_row_w_b[63:32];

    // stage 1: corner coordinates
    logic               r1_valid;
    logic [2:0]         r1_corner;
    logic [31:0]        r1_color;
    logic signed [31:0] r1_p [3];

    // stage 2: nine products
    logic               r2_valid;
    logic [2:0]         r2_corner;
    logic [31:0]        r2_color;
    logic signed [63:0] r2_m [9];

    // stage 3: clip x, y, w
    logic               r3_valid;
    logic [2:0]         r3_corner;
    logic [31:0]        r3_color;
    logic signed [31:0] r3_clip [3];
    logic               r3_vis;

    // divider chain, index 0 is the setup stage
    logic [bwp_pkg::DIV_STAGES:0] r_dv_valid;
    t_div                         r_dv [bwp_pkg::DIV_STAGES+1];

    // stage after divide: ndc
    logic               r5_valid;
    logic [2:0]         r5_corner;
    logic               r5_vis;
    logic [31:0]        r5_color;
    logic signed [31:0] r5_nx;
    logic signed [31:0] r5_ny;

    // screen products
    logic               r6_valid;
    logic [2:0]         r6_corner;
    logic               r6_vis;
    logic [31:0]        r6_color;
    logic signed [49:0] r6_mx;
    logic signed [49:0] r6_my;

    logic signed [63:0] w_sum [3];

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            w_sum[r] = (r2_m[3*r] >>> bwp_pkg::FRAC_BITS)
                     + (r2_m[3*r+1] >>> bwp_pkg::FRAC_BITS)
                     + (r2_m[3*r+2] >>> bwp_pkg::FRAC_BITS)
                     + 64'(w_off[r]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid   <= 1'b0;
            r2_valid   <= 1'b0;
            r3_valid   <= 1'b0;
            r_dv_valid <= '0;
            r5_valid   <= 1'b0;
            r6_valid   <= 1'b0;
            o_valid    <= 1'b0;
        end else if (i_en) begin
            r1_valid   <= i_valid;
            r2_valid   <= r1_valid;
            r3_valid   <= r2_valid;
            r_dv_valid <= {r_dv_valid[bwp_pkg::DIV_STAGES-1:0], r3_valid};
            r5_valid   <= r_dv_valid[bwp_pkg::DIV_STAGES];
            r6_valid   <= r5_valid;
            o_valid    <= r6_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_corner <= i_corner;
            r1_color  <= i_box.color_argb;
            r1_p[0]   <= corner_coord(i_box.center_x, i_box.box_width,
                                      i_corner[0] ^ i_corner[1]);
            r1_p[1]   <= corner_coord(i_box.center_y, i_box.box_height, i_corner[1]);
            r1_p[2]   <= corner_coord(i_box.center_z, i_box.box_depth, i_corner[2]);

            r2_corner <= r1_corner;
            r2_color  <= r1_color;
            for (int k = 0; k < 9; k++) begin
                r2_m[k] <= 64'(r1_p[k % 3]) * 64'(w_coef[k]);
            end

            r3_corner <= r2_corner;
            r3_color  <= r2_color;
            for (int r = 0; r < 3; r++) begin
                r3_clip[r] <= bwp_pkg::sat32(w_sum[r]);
            end
            r3_vis <= (i_row_x_a[31:0] != 32'd0)
                   && (w_sum[2] >= 64'(bwp_pkg::W_MIN) || bwp_pkg::sat32(w_sum[2]) >=
                       32'(bwp_pkg::W_MIN)) && (bwp_pkg::sat32(w_sum[2]) >=
                       32'(bwp_pkg::W_MIN));

            r_dv[0].corner <= r3_corner;
            r_dv[0].vis    <= r3_vis;
            r_dv[0].color  <= r3_color;
            r_dv[0].w      <= r3_vis ? 32'(r3_clip[2]) : 32'd1;
            r_dv[0].rem_x  <= '0;
            r_dv[0].num_x  <= abs_shift(r3_clip[0]);
            r_dv[0].neg_x  <= r3_clip[0][31];
            r_dv[0].rem_y  <= '0;
            r_dv[0].num_y  <= abs_shift(r3_clip[1]);
            r_dv[0].neg_y  <= r3_clip[1][31];

            r5_corner <= r_dv[bwp_pkg::DIV_STAGES].corner;
            r5_vis    <= r_dv[bwp_pkg::DIV_STAGES].vis;
            r5_color  <= r_dv[bwp_pkg::DIV_STAGES].color;
            r5_nx     <= quot_sat(r_dv[bwp_pkg::DIV_STAGES].num_x,
                                  r_dv[bwp_pkg::DIV_STAGES].neg_x);
            r5_ny     <= quot_sat(r_dv[bwp_pkg::DIV_STAGES].num_y,
                                  r_dv[bwp_pkg::DIV_STAGES].neg_y);

            r6_corner <= r5_corner;
            r6_vis    <= r5_vis;
            r6_color  <= r5_color;
            r6_mx     <= 50'(signed'({1'b0, i_screen_w}))
                       * 50'(34'(bwp_pkg::ONE_Q) + 34'(r5_nx));
            r6_my     <= 50'(signed'({1'b0, i_screen_h}))
                       * 50'(34'(bwp_pkg::ONE_Q) - 34'(r5_ny));

            o_res.corner <= r6_corner;
            o_res.vis    <= r6_vis;
            o_res.color  <= r6_color;
            o_res.sx     <= bwp_pkg::sat32(64'(r6_mx >>> 1));
            o_res.sy     <= bwp_pkg::sat32(64'(r6_my >>> 1));
        end
    end

    for (genvar s = 1; s <= bwp_pkg::DIV_STAGES; s++) begin : g_div
        t_dstep w_sx;
        t_dstep w_sy;

        assign w_sx = div_steps(r_dv[s-1].rem_x, r_dv[s-1].num_x, r_dv[s-1].w);
        assign w_sy = div_steps(r_dv[s-1].rem_y, r_dv[s-1].num_y, r_dv[s-1].w);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_dv[s].corner <= r_dv[s-1].corner;
                r_dv[s].vis    <= r_dv[s-1].vis;
                r_dv[s].color  <= r_dv[s-1].color;
                r_dv[s].w      <= r_dv[s-1].w;
                r_dv[s].neg_x  <= r_dv[s-1].neg_x;
                r_dv[s].neg_y  <= r_dv[s-1].neg_y;
                r_dv[s].rem_x  <= w_sx.rem;
                r_dv[s].num_x  <= w_sx.num;
                r_dv[s].rem_y  <= w_sy.rem;
                r_dv[s].num_y  <= w_sy.num;
            end
        end
    end

endmodule

[rtl/core/box_wireframe_projector.sv]
// box wireframe projector top level: config registers, corner sequencer,
// corner collector and edge emitter; depends on bwp_pkg and bwp_corner_pipe
`timescale 1ns / 1ps

// usage
//   input channel i_valid / o_ready carries one box word (center, extents,
//   color); output channel o_valid / i_ready carries one edge word per visible
//   edge, in edge table order, last_edge set on the final one of a box
//   config channel i_cfg_valid / o_cfg_ready writes register i_cfg_index with
//   i_cfg_data; always ready, indexes past the list are dropped
// timing
//   each box is cut into eight corners, one corner enters the projection
//   pipeline per cycle while it is not frozen; handing a full corner set to
//   the edge emitter freezes the pipeline until the emitter takes the set
//   the edge emitter sends one edge per cycle while i_ready is high, up to 12
//   per box; the arithmetic is Q16.16 and the divider resolves two quotient
//   bits a stage (24 stages)
// reset and stall
//   synchronous reset clears all valid bits and loads the register defaults
//   when i_ready stays low the output word holds, the emitter waits, the
//   collector fills and the whole pipeline freezes; nothing is lost

module box_wireframe_projector (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  bwp_pkg::t_box_in                i_data,
    output logic                            o_valid,
    input  logic                            i_ready,
    output bwp_pkg::t_edge_out              o_data,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [bwp_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [63:0]                     i_cfg_data
);

    typedef struct packed {
        logic signed [31:0] ax;
        logic signed [31:0] ay;
        logic signed [31:0] bx;
        logic signed [31:0] by;
    } t_seg;

    logic [63:0] r_row_x_a, r_row_x_b, r_row_y_a, r_row_y_b, r_row_w_a, r_row_w_b;
    logic [14:0] r_screen_w, r_screen_h;

    logic             r_busy;
    logic [2:0]       r_cnt;
    bwp_pkg::t_box_in r_box;

    logic                 w_en;
    logic                 w_pipe_valid;
    bwp_pkg::t_corner_res w_pipe_res;

    logic signed [31:0] r_cx [bwp_pkg::NUM_CORNERS];
    logic signed [31:0] r_cy [bwp_pkg::NUM_CORNERS];
    logic [bwp_pkg::NUM_CORNERS-1:0] r_cvis;
    logic [31:0]        r_col_color;
    logic               r_full;

    t_seg                          r_seg [bwp_pkg::NUM_EDGES];
    logic [bwp_pkg::NUM_EDGES-1:0] r_mask;
    logic [31:0]                   r_color;

    logic [3:0]                    w_sel;
    logic [bwp_pkg::NUM_EDGES-1:0] w_rest;
    logic [bwp_pkg::NUM_EDGES-1:0] w_new_mask;
    logic                          w_emit;
    logic                          w_load;
    logic                          w_write;
    logic                          w_accept;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_x_a  <= '0;
            r_row_x_b  <= '0;
            r_row_y_a  <= '0;
            r_row_y_b  <= '0;
            r_row_w_a  <= '0;
            r_row_w_b  <= '0;
            r_screen_w <= bwp_pkg::SCREEN_W_RST;
            r_screen_h <= bwp_pkg::SCREEN_H_RST;
        end else if (i_cfg_valid && !i_cfg_index[bwp_pkg::CFG_IDX_W-1]) begin
            unique case (bwp_pkg::t_cfg_idx'(i_cfg_index[2:0]))
                bwp_pkg::CFG_ROW_X_A:  r_row_x_a  <= i_cfg_data;
                bwp_pkg::CFG_ROW_X_B:  r_row_x_b  <= i_cfg_data;
                bwp_pkg::CFG_ROW_Y_A:  r_row_y_a  <= i_cfg_data;
                bwp_pkg::CFG_ROW_Y_B:  r_row_y_b  <= i_cfg_data;
                bwp_pkg::CFG_ROW_W_A:  r_row_w_a  <= i_cfg_data;
                bwp_pkg::CFG_ROW_W_B:  r_row_w_b  <= i_cfg_data;
                bwp_pkg::CFG_SCREEN_W: r_screen_w <= i_cfg_data[14:0];
                bwp_pkg::CFG_SCREEN_H: r_screen_h <= i_cfg_data[14:0];
                default: ;
            endcase
        end
    end

    // corner sequencer
    assign w_en     = !r_full;
    assign o_ready  = w_en && (!r_busy || r_cnt == 3'd7);
    assign w_accept = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            if (w_en && r_busy) begin
                r_cnt <= r_cnt + 3'd1;
                if (r_cnt == 3'd7) begin
                    r_busy <= 1'b0;
                end
            end
            if (w_accept) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_box <= i_data;
        end
    end

    bwp_corner_pipe u_pipe (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_en),
        .i_valid    (r_busy),
        .i_corner   (r_cnt),
        .i_box      (r_box),
        .i_row_x_a  (r_row_x_a),
        .i_row_x_b  (r_row_x_b),
        .i_row_y_a  (r_row_y_a),
        .i_row_y_b  (r_row_y_b),
        .i_row_w_a  (r_row_w_a),
        .i_row_w_b  (r_row_w_b),
        .i_screen_w (r_screen_w),
        .i_screen_h (r_screen_h),
        .o_valid    (w_pipe_valid),
        .o_res      (w_pipe_res)
    );

    // corner collector
    assign w_write = w_pipe_valid && w_en;

    always_ff @(posedge i_clk) begin
        if (w_write) begin
            r_cx[w_pipe_res.corner]   <= w_pipe_res.sx;
            r_cy[w_pipe_res.corner]   <= w_pipe_res.sy;
            r_cvis[w_pipe_res.corner] <= w_pipe_res.vis;
            r_col_color               <= w_pipe_res.color;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full <= 1'b0;
        end else if (w_write && w_pipe_res.corner == 3'd7) begin
            r_full <= 1'b1;
        end else if (w_load) begin
            r_full <= 1'b0;
        end
    end

    // edge emitter
    always_comb begin
        w_sel = '0;
        for (int e = bwp_pkg::NUM_EDGES - 1; e >= 0; e--) begin
            if (r_mask[e]) begin
                w_sel = 4'(e);
            end
        end
        w_rest = r_mask & ~(bwp_pkg::NUM_EDGES'(1) << w_sel);
        for (int e = 0; e < bwp_pkg::NUM_EDGES; e++) begin
            w_new_mask[e] = r_cvis[bwp_pkg::EDGE_A[e]] && r_cvis[bwp_pkg::EDGE_B[e]];
        end
    end

    assign w_emit = (r_mask != '0) && (!o_valid || i_ready);
    assign w_load = r_full && ((r_mask == '0) || (w_emit && w_rest == '0));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= '0;
        end else if (w_load) begin
            r_mask <= w_new_mask;
        end else if (w_emit) begin
            r_mask <= w_rest;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_color <= r_col_color;
            for (int e = 0; e < bwp_pkg::NUM_EDGES; e++) begin
                r_seg[e].ax <= r_cx[bwp_pkg::EDGE_A[e]];
                r_seg[e].ay <= r_cy[bwp_pkg::EDGE_A[e]];
                r_seg[e].bx <= r_cx[bwp_pkg::EDGE_B[e]];
                r_seg[e].by <= r_cy[bwp_pkg::EDGE_B[e]];
            end
        end
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (w_emit) begin
            o_valid <= 1'b1;
        end else if (i_ready) begin
            o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            o_data.start_x    <= r_seg[w_sel].ax;
            o_data.start_y    <= r_seg[w_sel].ay;
            o_data.end_x      <= r_seg[w_sel].bx;
            o_data.end_y      <= r_seg[w_sel].by;
            o_data.edge_index <= w_sel;
            o_data.edge_color <= r_color;
            o_data.last_edge  <= (w_rest == '0);
        end
    end

endmodule

[rtl/core/bwp_checker.sv]
// port checker for the box wireframe projector, bound to the top level
// depends on bwp_pkg and box_wireframe_projector_defines.svh
`timescale 1ns / 1ps

`include "box_wireframe_projector_defines.svh"

module bwp_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_valid,
    input logic               i_ready,
    input bwp_pkg::t_edge_out o_data
);

    `BWP_ASSERT_NEXT(a_out_hold, o_valid && !i_ready, o_valid)
    `BWP_ASSERT_NEXT(a_out_stable, o_valid && !i_ready, $stable(o_data))
    `BWP_ASSERT_SAME(a_edge_range, o_valid, o_data.edge_index <= 4'd11)
    `BWP_ASSERT_SAME(a_reset_quiet, $past(!i_rst_n), !o_valid)

endmodule

bind box_wireframe_projector bwp_checker u_bwp_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_valid (o_valid),
    .i_ready (i_ready),
    .o_data  (o_data)
);

[bench/tb_box_wireframe_projector.sv]
// testbench for box_wireframe_projector: drives box words, predicts the edge words
// of each box and checks them in order; depends on bwp_pkg and the rtl
`timescale 1ns / 1ps

module tb_box_wireframe_projector;

    localparam longint MAX32 = 64'sd2147483647;
    localparam longint MIN32 = -64'sd2147483648;
    localparam int LIMIT = 2000000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_ready;
    bwp_pkg::t_box_in i_data = '0;
    logic o_valid;
    logic i_ready = 1'b0;
    bwp_pkg::t_edge_out o_data;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [bwp_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [63:0] i_cfg_data = '0;

    box_wireframe_projector dut (.*);

    always #5 i_clk = ~i_clk;

    logic [63:0] mat_reg [6];
    logic [14:0] scr_w, scr_h;
    bwp_pkg::t_edge_out pending_edges [$];
    int mismatches = 0;
    int cycles = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_off = 0;

    function automatic longint sx32(logic [31:0] v);
        return longint'(signed'(v));
    endfunction

    function automatic longint clamp32(longint v);
        return v > MAX32 ? MAX32 : (v < MIN32 ? MIN32 : v);
    endfunction

    function automatic longint row_dot(int r, longint p[3]);
        longint s;
        s = ((p[0] * sx32(mat_reg[2*r][31:0])) >>> bwp_pkg::FRAC_BITS)
          + ((p[1] * sx32(mat_reg[2*r][63:32])) >>> bwp_pkg::FRAC_BITS)
          + ((p[2] * sx32(mat_reg[2*r+1][31:0])) >>> bwp_pkg::FRAC_BITS)
          + sx32(mat_reg[2*r+1][63:32]);
        return clamp32(s);
    endfunction

    task automatic predict_edges(bwp_pkg::t_box_in b);
        longint c[3], e[3], p[3], cx, cy, cw, nx, ny, d;
        longint px[8], py[8];
        bit vis[8];
        bwp_pkg::t_edge_out ed;
        int n;
        n = 0;
        c[0] = longint'(b.center_x);
        c[1] = longint'(b.center_y);
        c[2] = longint'(b.center_z);
        e[0] = longint'(b.box_width);
        e[1] = longint'(b.box_height);
        e[2] = longint'(b.box_depth);
        for (int i = 0; i < 8; i++) begin
            for (int k = 0; k < 3; k++) begin
                d = i[k] ? 2 * c[k] + e[k] : 2 * c[k] - e[k];
                if (k == 0) d = (i == 1 || i == 2 || i == 5 || i == 6) ?
                    2 * c[0] + e[0] : 2 * c[0] - e[0];
                if (k == 1) d = (i == 2 || i == 3 || i == 6 || i == 7) ?
                    2 * c[1] + e[1] : 2 * c[1] - e[1];
                p[k] = clamp32(d >>> 1);
            end
            px[i] = 0; py[i] = 0; vis[i] = 0;
            if (mat_reg[0][31:0] != 0) begin
                cx = row_dot(0, p);
                cy = row_dot(1, p);
                cw = row_dot(2, p);
                if (cw >= bwp_pkg::W_MIN) begin
                    vis[i] = 1;
                    nx = clamp32((cx * bwp_pkg::ONE_Q) / cw);
                    ny = clamp32((cy * bwp_pkg::ONE_Q) / cw);
                    px[i] = clamp32((longint'(scr_w) * (bwp_pkg::ONE_Q + nx)) >>> 1);
                    py[i] = clamp32((longint'(scr_h) * (bwp_pkg::ONE_Q - ny)) >>> 1);
                end
            end
        end
        for (int i = 0; i < bwp_pkg::NUM_EDGES; i++) begin
            if (vis[bwp_pkg::EDGE_A[i]] && vis[bwp_pkg::EDGE_B[i]]) begin
                ed.start_x = px[bwp_pkg::EDGE_A[i]][31:0];
                ed.start_y = py[bwp_pkg::EDGE_A[i]][31:0];
                ed.end_x = px[bwp_pkg::EDGE_B[i]][31:0];
                ed.end_y = py[bwp_pkg::EDGE_B[i]][31:0];
                ed.edge_index = i[3:0];
                ed.edge_color = b.color_argb;
                ed.last_edge = 1'b0;
                pending_edges = {pending_edges, ed};
                n++;
            end
        end
        if (n > 0) pending_edges[pending_edges.size() - 1].last_edge = 1'b1;
    endtask

    task automatic send_box(bwp_pkg::t_box_in b);
        while (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data <= b;
        predict_edges(b);
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic write_reg(bwp_pkg::t_cfg_idx idx, logic [63:0] v);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= bwp_pkg::CFG_IDX_W'(idx);
        i_cfg_data <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
        if (idx == bwp_pkg::CFG_SCREEN_W) scr_w = v[14:0];
        else if (idx == bwp_pkg::CFG_SCREEN_H) scr_h = v[14:0];
        else mat_reg[int'(idx)] = v;
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (pending_edges.size() != 0) @(posedge i_clk);
        repeat (bwp_pkg::DIV_STAGES + 100) @(posedge i_clk);
    endtask

    function automatic logic [63:0] coef_pair(longint a, longint b);
        return {b[31:0], a[31:0]};
    endfunction

    // plain perspective: x and y scaled, w = z
    task automatic load_view(longint k, logic [14:0] w, logic [14:0] h);
        write_reg(bwp_pkg::CFG_ROW_X_A, coef_pair(k, 0));
        write_reg(bwp_pkg::CFG_ROW_X_B, coef_pair(0, 0));
        write_reg(bwp_pkg::CFG_ROW_Y_A, coef_pair(0, k));
        write_reg(bwp_pkg::CFG_ROW_Y_B, coef_pair(0, 0));
        write_reg(bwp_pkg::CFG_ROW_W_A, coef_pair(0, 0));
        write_reg(bwp_pkg::CFG_ROW_W_B, coef_pair(bwp_pkg::ONE_Q, 0));
        write_reg(bwp_pkg::CFG_SCREEN_W, 64'(w));
        write_reg(bwp_pkg::CFG_SCREEN_H, 64'(h));
    endtask

    function automatic bwp_pkg::t_box_in rand_box(bit near);
        bwp_pkg::t_box_in b;
        b.center_x = $urandom;
        b.center_y = $urandom;
        b.center_z = $urandom;
        b.box_width = 31'($urandom);
        b.box_height = 31'($urandom);
        b.box_depth = 31'($urandom);
        b.color_argb = $urandom;
        if (near) begin
            b.center_x = $signed($urandom_range(40 << 16, 0)) - (20 << 16);
            b.center_y = $signed($urandom_range(40 << 16, 0)) - (20 << 16);
            b.center_z = $urandom_range(30 << 16, 2 << 16);
            b.box_width = 31'($urandom_range(8 << 16, 0));
            b.box_height = 31'($urandom_range(8 << 16, 0));
            b.box_depth = 31'($urandom_range(3 << 16, 0));
        end
        return b;
    endfunction

    task automatic test_reset_defaults();
        // x weight zero after reset: nothing comes out
        send_box(rand_box(1));
        send_box(rand_box(0));
        drain();
    endtask

    task automatic test_directed();
        bwp_pkg::t_box_in b;
        load_view(bwp_pkg::ONE_Q, 15'd1920, 15'd1080);
        b = '0;
        b.center_z = 32'(5 << 16); b.box_width = 31'(2 << 16);
        b.box_height = 31'(2 << 16);
        b.box_depth = 31'(2 << 16); b.color_argb = 32'hFF00FF00;
        send_box(b);
        b.box_width = '0; b.box_height = '0; b.box_depth = '0;
        send_box(b);
        // face at lower z hidden near w boundary
        b.center_z = 32'(bwp_pkg::W_MIN); b.box_depth = 31'd2;
        b.box_width = 31'(1 << 16);
        send_box(b);
        b.center_z = '0; b.box_depth = 31'h7FFFFFFF;
        send_box(b);
        b = '1;
        send_box(b);
        b = '0;
        b.center_x = 32'sh7FFFFFFF; b.center_y = 32'sh80000000;
        b.center_z = 32'sh7FFFFFFF;
        b.box_width = 31'h7FFFFFFF; b.box_height = 31'h7FFFFFFF;
        b.box_depth = 31'h7FFFFFFF; b.color_argb = 32'hFFFFFFFF;
        send_box(b);
        b.center_x = 32'sh80000000; b.center_y = 32'sh7FFFFFFF;
        b.center_z = 32'(1 << 16);
        send_box(b);
        // tiny w, screen x saturates
        b = '0; b.center_x = 32'(1000 << 16); b.center_z = 32'(bwp_pkg::W_MIN);
        send_box(b);
        drain();
        load_view(bwp_pkg::ONE_Q, 15'd0, 15'h7FFF);
        send_box(rand_box(1));
        send_box(b);
        drain();
        load_view(bwp_pkg::ONE_Q, 15'd1, 15'd16384);
        send_box(rand_box(1));
        b.center_x = 32'(-(1000 << 16));
        send_box(b);
        drain();
        for (int i = 0; i < 6; i++) write_reg(bwp_pkg::t_cfg_idx'(i), {$urandom, $urandom});
        write_reg(bwp_pkg::CFG_SCREEN_W, 64'h7FFF); write_reg(bwp_pkg::CFG_SCREEN_H, 64'h1);
        repeat (4) send_box(rand_box(0));
        drain();
        for (int i = 0; i < 6; i++) write_reg(bwp_pkg::t_cfg_idx'(i), '1);
        repeat (2) send_box(rand_box(1));
        drain();
        // index past the list is dropped
        i_cfg_valid <= 1'b1; i_cfg_index <= '1; i_cfg_data <= '0;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
        load_view(bwp_pkg::ONE_Q / 2, 15'd640, 15'd480);
        send_box(rand_box(1));
        drain();
    endtask

    task automatic test_random(int count, int idle, int stall);
        send_idle_pct = idle;
        recv_stall_pct = stall;
        for (int i = 0; i < count; i++)
            send_box(rand_box($urandom_range(9, 0) < 8));
        drain();
        send_idle_pct = 0;
        recv_stall_pct = 0;
    endtask

    task automatic test_backpressure();
        hold_off = 600;
        repeat (40) send_box(rand_box(1));
        drain();
    endtask

    always @(posedge i_clk) begin
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= $urandom_range(99, 0) >= recv_stall_pct;
        end
    end

    always @(posedge i_clk) begin
        bwp_pkg::t_edge_out exp_e;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_edges.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected edge word %p", o_data);
            end else begin
                exp_e = pending_edges.pop_front();
                if (o_data !== exp_e) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("edge mismatch exp %p got %p", exp_e, o_data);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT) begin
            $display("tb_box_wireframe_projector NOT OK");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < 6; i++) mat_reg[i] = '0;
        scr_w = bwp_pkg::SCREEN_W_RST;
        scr_h = bwp_pkg::SCREEN_H_RST;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_defaults();
        test_directed();
        load_view(bwp_pkg::ONE_Q, 15'd1920, 15'd1080);
        test_random(105, 0, 0);
        load_view(bwp_pkg::ONE_Q * 2, 15'd800, 15'd600);
        test_random(105, 45, 0);
        test_random(105, 0, 45);
        load_view(bwp_pkg::ONE_Q, 15'd16384, 15'd1);
        test_random(105, 8, 8);
        test_backpressure();
        if (mismatches == 0 && pending_edges.size() == 0) begin
            $display("tb_box_wireframe_projector OK");
        end else begin
            $display("tb_box_wireframe_projector NOT OK");
        end
        $finish;
    end
endmodule

[files.f]
+incdir+rtl/core
rtl/core/bwp_pkg.sv
rtl/core/bwp_corner_pipe.sv
rtl/core/box_wireframe_projector.sv
rtl/core/bwp_checker.sv
bench/tb_box_wireframe_projector.sv
